@@ rtl/pba_pkg.sv @@
// shared types and constants of the packed bit-field array
`default_nettype none
package pba_pkg;

	// field widths of the words
	localparam int WID_W   = 7;   // element width register
	localparam int BYTE_W  = 12;  // base byte register
	localparam int BIT_W   = 3;   // base bit register
	localparam int IDX_W   = 15;  // element index
	localparam int VAL_W   = 64;  // element value
	localparam int PROD_W  = WID_W + IDX_W;
	localparam int POS_W   = 24;  // bit address, wide enough for up to 2**21 bytes
	localparam int SHIFT_W = 7;   // bit offset inside the element, up to 64

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_BYTE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_BIT      = 2'd2;
	localparam logic [WID_W-1:0]     WIDTH_RESET       = 7'd8;

	// opcodes
	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/pba_if.sv @@
// channel interfaces of the packed bit-field array
`default_nettype none

// request word: set or get one element
interface pba_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [pba_pkg::IDX_W-1:0] element_index;
	logic [pba_pkg::VAL_W-1:0] write_value;

	modport source (output valid, output opcode, output element_index, output write_value,
		input ready);
	modport sink (input valid, input opcode, input element_index, input write_value,
		output ready);
endinterface

// response word: one per request
interface pba_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [pba_pkg::VAL_W-1:0] read_value;
	logic                      range_error;

	modport source (output valid, output read_value, output range_error, input ready);
	modport sink (input valid, input read_value, input range_error, output ready);
endinterface

// configuration register writes
interface pba_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pba_pkg::CFG_IDX_W-1:0]  index;
	logic [pba_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/pba_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/packed_bitfield_array.sv @@
// top level of the packed bit-field array: sequencer, byte walker and result register
//
// Elements of element_width bits are packed LSB-first into a byte memory of
// MEM_BYTES bytes, element k starting at bit base_byte*8 + base_bit + width*k.
// req carries one word (opcode, element_index, write_value); each word gives
// exactly one rsp word (read_value, range_error). A set does read-modify-write
// on every byte the element touches; a get returns the element zero-extended.
// cfg writes element_width, base_byte and base_bit by index; it is always
// ready and is meant to be written while no request is in flight.
// After reset the memory is cleared one byte per cycle, during which req is
// not ready. Registers reset to width 8, base zero.
// A request passes through multiply, range check, one memory read per byte
// touched (1 to 9 bytes; a zero width or out-of-range element touches no
// byte), where for a set the write-back of a byte overlaps the read of the
// next on the two-port byte ram and a last write-back follows, then a drain
// step and the result load; req is not ready again until that load.
// The result sits in an output register; a stalled rsp holds the block in
// its final state only when a second result is ready to be loaded.
`default_nettype none
module packed_bitfield_array #(
	parameter int MEM_BYTES = 4096,
	parameter int MAX_WIDTH = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pba_req_if.sink    req,
	pba_rsp_if.source  rsp,
	pba_cfg_if.sink    cfg
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int PW = pba_pkg::POS_W;
	localparam int WW = pba_pkg::WID_W;
	localparam int VW = pba_pkg::VAL_W;
	localparam int SW = pba_pkg::SHIFT_W;
	localparam int XW = pba_pkg::PROD_W;
	localparam logic [PW-1:0] MEM_BITS = PW'(MEM_BYTES * 8);
	localparam logic [WW-1:0] WMAX     = WW'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST     = AW'(MEM_BYTES - 1);

	pba_pkg::state_t state_q, state_d;

	// configuration registers
	logic [WW-1:0]                width_cfg_q;
	logic [pba_pkg::BYTE_W-1:0]   base_byte_q;
	logic [pba_pkg::BIT_W-1:0]    base_bit_q;

	// item registers
	logic                       op_q;
	logic [pba_pkg::IDX_W-1:0]  idx_q;
	logic [VW-1:0]              wv_q;
	logic [WW-1:0]              width_q;
	logic [PW-1:0]              base_q;
	logic [XW-1:0]              prod_q;
	logic                       err_q;
	logic [PW-1:0]              pos_q;
	logic [WW-1:0]              left_q;
	logic [SW-1:0]              shift_q;
	logic [VW-1:0]              ret_q;
	logic [AW-1:0]              clr_q;

	// byte in flight between read and write-back
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    bmask_s1;
	logic [2:0]    off_s1;
	logic [SW-2:0] shift_s1;

	// result register
	logic          out_vld_q;
	logic [VW-1:0] rv_q;
	logic          re_q;

	// control outputs of the sequencer
	logic          req_ready;
	logic          out_load;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// datapath
	logic [WW-1:0] eff_width;
	logic [PW-1:0] start;
	logic [PW-1:0] stop;
	logic          err;
	logic [2:0]    off;
	logic [3:0]    room;
	logic [3:0]    n;
	logic [8:0]    fmask;
	logic [7:0]    bmask;
	logic [7:0]    part;
	logic [7:0]    wbyte;
	logic [VW-1:0] gathered;

	// width saturated to the largest supported element
	assign eff_width = (width_cfg_q > WMAX) ? WMAX : width_cfg_q;

	// element bounds and range check
	assign start = base_q + PW'(prod_q);
	assign stop  = start + PW'(width_q);
	assign err   = (width_q != '0) && (stop > MEM_BITS);

	// slice of the element that falls in the current byte
	assign off   = pos_q[2:0];
	assign room  = 4'd8 - {1'b0, off};
	assign n     = (left_q < WW'(room)) ? left_q[3:0] : room;
	assign fmask = (9'd1 << n) - 9'd1;
	assign bmask = fmask[7:0] << off;

	// merge for a set, align for a get
	assign part     = 8'(wv_q >> shift_s1);
	assign wbyte    = (ram_rdata & ~bmask_s1) | ((part << off_s1) & bmask_s1);
	assign gathered = VW'((ram_rdata & bmask_s1) >> off_s1) << shift_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pba_pkg::ST_CLEAR: begin
				if (clr_q == LAST) state_d = pba_pkg::ST_IDLE;
			end
			pba_pkg::ST_IDLE: begin
				if (req.valid) state_d = pba_pkg::ST_MUL;
			end
			pba_pkg::ST_MUL: begin
				state_d = pba_pkg::ST_CHECK;
			end
			pba_pkg::ST_CHECK: begin
				state_d = pba_pkg::ST_WALK;
			end
			pba_pkg::ST_WALK: begin
				if (left_q == '0 && !vld_s1) state_d = pba_pkg::ST_DONE;
			end
			pba_pkg::ST_DONE: begin
				if (out_load) state_d = pba_pkg::ST_IDLE;
			end
			default: begin
				state_d = pba_pkg::ST_CLEAR;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = wbyte;
		ram_re    = 1'b0;
		ram_raddr = pos_q[AW+2:3];
		case (state_q)
			pba_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			pba_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			pba_pkg::ST_WALK: begin
				ram_re = (left_q != '0);
				ram_we = vld_s1 && (op_q == pba_pkg::OP_SET);
			end
			pba_pkg::ST_DONE: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// state and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pba_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pba_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q <= pba_pkg::WIDTH_RESET;
			base_byte_q <= '0;
			base_bit_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				pba_pkg::REG_ELEMENT_WIDTH: width_cfg_q <= cfg.data[WW-1:0];
				pba_pkg::REG_BASE_BYTE:     base_byte_q <= cfg.data;
				pba_pkg::REG_BASE_BIT:      base_bit_q  <= cfg.data[pba_pkg::BIT_W-1:0];
				default:                    base_bit_q  <= base_bit_q;
			endcase
		end
	end

	// item capture, multiply, range check and byte walk
	always_ff @(posedge clk) begin
		case (state_q)
			pba_pkg::ST_IDLE: begin
				op_q    <= req.opcode;
				idx_q   <= req.element_index;
				wv_q    <= req.write_value;
				width_q <= eff_width;
				base_q  <= PW'({base_byte_q, base_bit_q});
			end
			pba_pkg::ST_MUL: begin
				prod_q <= width_q * XW'(idx_q);
			end
			pba_pkg::ST_CHECK: begin
				err_q   <= err;
				pos_q   <= start;
				left_q  <= (width_q != '0 && !err) ? width_q : '0;
				shift_q <= '0;
				ret_q   <= '0;
			end
			pba_pkg::ST_WALK: begin
				if (ram_re) begin
					pos_q   <= pos_q + PW'(n);
					left_q  <= left_q - WW'(n);
					shift_q <= shift_q + SW'(n);
				end
				if (vld_s1 && op_q == pba_pkg::OP_GET) ret_q <= ret_q | gathered;
			end
			default: begin
				ret_q <= ret_q;
			end
		endcase
	end

	// byte stage between memory read and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			addr_s1  <= ram_raddr;
			bmask_s1 <= bmask;
			off_s1   <= off;
			shift_s1 <= shift_q[SW-2:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rv_q <= ret_q;
			re_q <= err_q;
		end
	end

	// byte memory
	pba_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// port drive
	assign req.ready       = req_ready;
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_vld_q;
	assign rsp.read_value  = rv_q;
	assign rsp.range_error = re_q;

	// an out-of-range element never returns data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.read_value == '0)
		else $error("range error with nonzero read value");

	// write-back never collides with the read of the next byte
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("byte write and read at same address");

	// bits consumed plus bits left always add up to the element width
	a_walk_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pba_pkg::ST_WALK && !err_q && width_q != '0
		|-> WW'(shift_q + SW'(left_q)) == width_q)
		else $error("walker lost track of element bits");

	// a byte in flight always finishes before the result is formed
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pba_pkg::ST_DONE |-> !vld_s1 && left_q == '0)
		else $error("result formed while a byte is in flight");

	// the walk only starts after the range check
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == pba_pkg::ST_WALK) |-> $past(state_q) == pba_pkg::ST_CHECK)
		else $error("walk entered without range check");

endmodule
`default_nettype wire

@@ test/pba_monitor.sv @@
// bus monitor of the packed bit-field array: mirrors the byte memory and checks every reply word
module pba_monitor #(
	parameter int MEM_BYTES = 4096,
	parameter int MAX_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pba_req_if        req,
	pba_rsp_if        rsp,
	pba_cfg_if        cfg,
	input  wire logic wrap_up,
	output int        errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import pba_pkg::*;

	localparam int SHOW_LIMIT = 100;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             range_error;
	} reply_t;

	// mirror of the memory and the registers
	logic [7:0]        shadow_bytes [MEM_BYTES];
	logic [WID_W-1:0]  width_reg;
	logic [BYTE_W-1:0] base_byte_reg;
	logic [BIT_W-1:0]  base_bit_reg;
	reply_t            owed_replies [$];
	int                shown = 0;
	logic              wrapped = 1'b0;

	initial errors = 0;

	// one set or get on the mirror, bit by bit from the element start
	task automatic apply_access(input logic op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] value, output reply_t reply);
		int unsigned w;
		int unsigned first;
		int unsigned addr;
		int unsigned i;
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		first = base_byte_reg * 8 + base_bit_reg + w * idx;
		reply = '0;
		if (w != 0) begin
			if (first + w > MEM_BYTES * 8) begin
				reply.range_error = 1'b1;
			end else begin
				for (i = 0; i < w; i++) begin
					addr = first + i;
					if (op == OP_SET)
						shadow_bytes[addr / 8][addr % 8] = value[i];
					else
						reply.read_value[i] = shadow_bytes[addr / 8][addr % 8];
				end
			end
		end
	endtask

	task automatic flag_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] seen);
		errors++;
		if (shown < SHOW_LIMIT)
			$display("%0t ns: reply %s wrong, expected %h, got %h", $time, name, want, seen);
		else if (shown == SHOW_LIMIT)
			$display("%0t ns: further mismatches not listed", $time);
		shown++;
	endtask

	// watch the three channels, replies first so a word never meets its own request
	always @(posedge clk or negedge arst_n) begin
		reply_t due;
		reply_t fresh;
		if (!arst_n) begin
			foreach (shadow_bytes[i])
				shadow_bytes[i] = '0;
			width_reg = WIDTH_RESET;
			base_byte_reg = '0;
			base_bit_reg = '0;
			owed_replies.delete();
		end else begin
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (owed_replies.size() != 0) begin
					$display("%0t ns: %0d reply words never arrived", $time,
						owed_replies.size());
					errors += owed_replies.size();
				end
			end

			// reply word
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					errors++;
					$display("%0t ns: reply word with no request pending, got %h / %b",
						$time, rsp.read_value, rsp.range_error);
				end else begin
					due = owed_replies.pop_front();
					if (rsp.read_value !== due.read_value)
						flag_field("read_value", due.read_value, rsp.read_value);
					if (rsp.range_error !== due.range_error)
						flag_field("range_error", VAL_W'(due.range_error),
							VAL_W'(rsp.range_error));
				end
			end

			// register write, unknown indexes change nothing
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ELEMENT_WIDTH: width_reg = cfg.data[WID_W-1:0];
					REG_BASE_BYTE:     base_byte_reg = cfg.data[BYTE_W-1:0];
					REG_BASE_BIT:      base_bit_reg = cfg.data[BIT_W-1:0];
					default: ;
				endcase
			end

			// request word
			if (req.valid && req.ready) begin
				apply_access(req.opcode, req.element_index, req.write_value, fresh);
				owed_replies.push_back(fresh);
			end
		end
	end

endmodule

@@ test/testbench.sv @@
// top of the packed bit-field array test: clock, reset, stimulus, reply flow control and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pba_pkg::*;

	localparam int MEM_BYTES      = 4096;
	localparam int MAX_WIDTH      = 64;
	localparam int TOTAL_BITS     = MEM_BYTES * 8;
	localparam int IDX_MAX        = (1 << IDX_W) - 1;
	localparam int RANDOM_WORDS   = 1650;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 20;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_RANDOM,
		FLOW_PERIODIC,
		FLOW_SPARSE
	} flow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	logic wrap_up = 1'b0;
	int   errors;
	int   sent_count = 0;
	int   get_count = 0;
	int   replies_seen = 0;
	int   range_hits = 0;
	int   settings_count = 1;
	int   idle_cycles = 0;
	int   burst_left = 1;
	flow_t      flow_mode = FLOW_FREE;
	logic [6:0] flow_cnt = '0;

	pba_req_if req_ch ();
	pba_rsp_if rsp_ch ();
	pba_cfg_if cfg_ch ();

	assign rsp_ch.ready = sink_ready;

	packed_bitfield_array #(
		.MEM_BYTES (MEM_BYTES),
		.MAX_WIDTH (MAX_WIDTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pba_monitor #(
		.MEM_BYTES (MEM_BYTES),
		.MAX_WIDTH (MAX_WIDTH)
	) u_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.wrap_up (wrap_up),
		.errors  (errors)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// reply side stalls, the pattern is picked anew each time flow_cnt wraps
	always @(posedge clk) begin
		flow_cnt <= flow_cnt + 1'b1;
		if (flow_cnt == '1)
			flow_mode <= flow_t'($urandom_range(0, 3));
		case (flow_mode)
			FLOW_FREE:     sink_ready <= 1'b1;
			FLOW_RANDOM:   sink_ready <= ($urandom_range(0, 9) < 6);
			FLOW_PERIODIC: sink_ready <= (flow_cnt[2:0] < 3'd3);
			default:       sink_ready <= (flow_cnt[4:0] == '0);
		endcase
	end

	// reply count and watchdog on cycles without any word moving
	always @(posedge clk) begin
		if (arst_n && ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			replies_seen <= replies_seen + 1;
			if (rsp_ch.range_error)
				range_hits <= range_hits + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// one request word, then a random gap at the end of a burst
	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] value);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.element_index <= idx;
		req_ch.write_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_count++;
		if (op == OP_GET)
			get_count++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_replies();
		while (replies_seen != sent_count)
			@(posedge clk);
	endtask

	// register write word, valid stays up for the next one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	// new layout once the block has gone quiet; unused data bits are random
	task automatic apply_settings(input logic [WID_W-1:0] w, input logic [BYTE_W-1:0] bb,
			input logic [BIT_W-1:0] bb_bit, input logic with_unused);
		logic [CFG_DATA_W-1:0] data;
		req_ch.valid <= 1'b0;
		wait_replies();
		if (with_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		data = CFG_DATA_W'($urandom);
		data[WID_W-1:0] = w;
		write_reg(REG_ELEMENT_WIDTH, data);
		write_reg(REG_BASE_BYTE, bb);
		data = CFG_DATA_W'($urandom);
		data[BIT_W-1:0] = bb_bit;
		write_reg(REG_BASE_BIT, data);
		cfg_ch.valid <= 1'b0;
		settings_count++;
	endtask

	initial begin
		logic [WID_W-1:0]  w;
		logic [BYTE_W-1:0] bb;
		logic [BIT_W-1:0]  bb_bit;
		logic [VAL_W-1:0]  value;
		logic              op;
		int eff_w;
		int base_pos;
		int max_ok;
		int win_base;
		int phase_len;
		int pick;
		int sel;
		int k;
		int random_sent;

		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_SET;
		req_ch.element_index <= '0;
		req_ch.write_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ELEMENT_WIDTH;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset layout: byte elements from bit zero, first and last byte, past the end
		send_item(OP_SET, 15'd0, '1);
		send_item(OP_GET, 15'd0, '0);
		send_item(OP_SET, 15'd4095, 64'hA5);
		send_item(OP_GET, 15'd4095, '0);
		send_item(OP_SET, 15'd4096, '1);
		send_item(OP_GET, '1, '0);
		send_item(OP_SET, 15'd1, '0);
		send_item(OP_GET, 15'd1, '0);

		// widest element spanning nine bytes and ending one bit before the last bit
		apply_settings(7'd64, 12'd4087, 3'd7, 1'b1);
		send_item(OP_SET, 15'd0, '1);
		send_item(OP_GET, 15'd0, '0);
		send_item(OP_SET, 15'd1, '1);

		// single bits around it: neighbors kept on both sides
		apply_settings(7'd1, 12'd4087, 3'd6, 1'b0);
		send_item(OP_GET, 15'd0, '0);
		send_item(OP_GET, 15'd64, '0);
		send_item(OP_GET, 15'd65, '0);

		// zero width: nothing stored, no error
		apply_settings(7'd0, 12'd5, 3'd2, 1'b1);
		send_item(OP_SET, 15'd3, {$urandom, $urandom});
		send_item(OP_GET, 15'd3, '0);

		// width above the maximum saturates
		apply_settings(7'd127, 12'd0, 3'd3, 1'b0);
		send_item(OP_SET, 15'd0, {$urandom, $urandom});
		send_item(OP_GET, 15'd0, '0);
		send_item(OP_GET, 15'd510, '0);
		send_item(OP_GET, 15'd511, '0);

		// last bit of the memory
		apply_settings(7'd1, '1, '1, 1'b0);
		send_item(OP_SET, 15'd0, 64'd1);
		send_item(OP_GET, 15'd0, '0);
		send_item(OP_GET, 15'd1, '0);

		// random layouts, mostly words into a small window of valid elements
		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 19))
				0:       w = '0;
				1, 2:    w = 7'd1;
				3, 4:    w = WID_W'(MAX_WIDTH);
				5:       w = WID_W'($urandom_range(MAX_WIDTH + 1, (1 << WID_W) - 1));
				default: w = WID_W'($urandom_range(1, MAX_WIDTH));
			endcase
			case ($urandom_range(0, 9))
				0:       bb = '1;
				1:       bb = '0;
				2:       bb = BYTE_W'($urandom_range(4000, MEM_BYTES - 1));
				default: bb = BYTE_W'($urandom_range(0, 3500));
			endcase
			bb_bit = BIT_W'($urandom_range(0, 7));
			apply_settings(w, bb, bb_bit, $urandom_range(0, 3) == 0);

			eff_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
			base_pos = bb * 8 + bb_bit;
			if (eff_w == 0 || base_pos + eff_w > TOTAL_BITS) begin
				max_ok = -1;
			end else begin
				max_ok = (TOTAL_BITS - base_pos - eff_w) / eff_w;
				if (max_ok > IDX_MAX)
					max_ok = IDX_MAX;
			end
			win_base = (max_ok < 0) ? 0 : $urandom_range(0, max_ok);
			phase_len = $urandom_range(60, 140);

			for (k = 0; k < phase_len && random_sent < RANDOM_WORDS; k++) begin
				sel = $urandom_range(0, 19);
				if (max_ok < 0 || sel < 2) begin
					pick = $urandom_range(0, IDX_MAX);
				end else if (sel < 5) begin
					// around the last element that still fits
					pick = max_ok + int'($urandom_range(0, 4)) - 2;
					if (pick < 0)
						pick = 0;
					if (pick > IDX_MAX)
						pick = IDX_MAX;
				end else if (sel < 6) begin
					pick = $urandom_range(0, max_ok);
				end else begin
					pick = win_base + int'($urandom_range(0, 15));
					if (pick > max_ok)
						pick = max_ok;
				end
				case ($urandom_range(0, 15))
					0:       value = '0;
					1:       value = '1;
					default: value = {$urandom, $urandom};
				endcase
				op = ($urandom_range(0, 1) == 0) ? OP_SET : OP_GET;
				send_item(op, IDX_W'(pick), value);
				random_sent++;
				if (max_ok >= 0 && $urandom_range(0, 39) == 0)
					win_base = $urandom_range(0, max_ok);
			end
		end

		// drain and settle
		req_ch.valid <= 1'b0;
		wait_replies();
		wrap_up <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d request words (%0d gets) over %0d register layouts",
			sent_count, get_count, settings_count);
		$display("%0d replies flagged out of range, %0d mismatches", range_hits, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
